@@ rtl/core/mcu_port_shared_ram_bridge_macros.svh @@
// Assertion macros shared by the bridge checker.
`ifndef MCU_PORT_SHARED_RAM_BRIDGE_MACROS_SVH
`define MCU_PORT_SHARED_RAM_BRIDGE_MACROS_SVH

// Property checked on every rising edge, off while reset is held.
`define MPSRB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every rising edge, off while reset is held.
`define MPSRB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/mpsrb_pkg.sv @@
// Types, constants and helpers for the port bridge.
package mpsrb_pkg;

  localparam int MEM_DEPTH = 1024;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int ADDR_W    = 12;
  localparam int RAM_IDX_W = 10;
  localparam int P1_IRQ_BIT  = 6;
  localparam int P1_COIN_BIT = 4;
  localparam int P1_DIR_BIT  = 7;
  localparam int P2_STB_BIT  = 4;
  localparam int ADDR_SW_BIT = 11;

  typedef enum logic [2:0] {
    ACT_P1_WR  = 3'd0,
    ACT_P2_WR  = 3'd1,
    ACT_P3_WR  = 3'd2,
    ACT_P4_WR  = 3'd3,
    ACT_P3_RD  = 3'd4,
    ACT_VEC_RD = 3'd5
  } action_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data;
    logic [7:0] dip_switch_a;
    logic [7:0] dip_switch_b;
    logic [7:0] player_input_a;
    logic [7:0] player_input_b;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       host_irq;
    logic       coin_lock;
  } out_item_t;

  // Fold a 10-bit RAM index into the memory depth; depth is at least a quarter of 1024.
  function automatic logic [MEM_AW-1:0] mem_index(input logic [RAM_IDX_W-1:0] a);
    logic [RAM_IDX_W:0] v;
    v = {1'b0, a};
    for (int i = 0; i < 3; i++) begin
      if (v >= (RAM_IDX_W + 1)'(MEM_DEPTH)) begin
        v = v - (RAM_IDX_W + 1)'(MEM_DEPTH);
      end
    end
    return v[MEM_AW-1:0];
  endfunction

endpackage

@@ rtl/core/mpsrb_ram.sv @@
// Generic single-port RAM with registered read.
module mpsrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ rtl/core/mcu_port_shared_ram_bridge.sv @@
// Top level of the port bridge: port latches, access decode and shared RAM.
//
//   channel | dir | handshake              | word
//   in_     | in  | in_valid / in_ready    | in_item  (in_item_t)
//   out_    | out | out_valid / out_ready  | out_item (out_item_t)
//
// Port writes and port-3 reads finish when accepted; a vector read or a RAM read access
// also holds the input off in the READ state, as the shared RAM's read is registered.
// The vector read's result is loaded into the result register from the READ state.
// One word is in work at a time; a new word enters only while the result register
// is empty or drains in the same cycle. Reset clears all latches and the interrupt;
// RAM is not cleared. A stalled output holds the input off for as long as it stalls.
module mcu_port_shared_ram_bridge
  import mpsrb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  state_t    state_r, state_nxt;
  logic [7:0] port1_last_r, port1_last_nxt;
  logic [7:0] port2_last_r, port2_last_nxt;
  logic [7:0] p3_out_r, p3_out_nxt;
  logic [7:0] p3_in_r, p3_in_nxt;
  logic [7:0] addr_lo_r, addr_lo_nxt;
  logic       irq_r, irq_nxt;
  logic       lock_r, lock_nxt;
  logic       rd_vec_r, rd_vec_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r, out_item_nxt;

  logic              accept;
  logic [ADDR_W-1:0] acc_addr;
  logic [MEM_AW-1:0] ram_addr;
  logic              ram_we, ram_re, ram_vec;
  logic [7:0]        ram_rdata;
  logic [7:0]        sw_byte;
  logic [7:0]        rd_byte;

  assign acc_addr = {in_item.data[3:0], addr_lo_r};
  assign ram_addr = ram_vec ? '0 : mem_index(acc_addr[RAM_IDX_W-1:0]);

  always_comb begin
    case (acc_addr[1:0])
      2'd0:    sw_byte = in_item.dip_switch_a;
      2'd1:    sw_byte = in_item.dip_switch_b;
      2'd2:    sw_byte = in_item.player_input_a;
      default: sw_byte = in_item.player_input_b;
    endcase
  end

  mpsrb_ram #(
    .WIDTH(8),
    .DEPTH(MEM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(p3_out_r),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    port1_last_nxt = port1_last_r;
    port2_last_nxt = port2_last_r;
    p3_out_nxt     = p3_out_r;
    p3_in_nxt      = p3_in_r;
    addr_lo_nxt    = addr_lo_r;
    irq_nxt        = irq_r;
    lock_nxt       = lock_r;
    rd_vec_nxt     = rd_vec_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_item_nxt   = out_item_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_vec        = 1'b0;
    rd_byte        = '0;
    in_ready       = 1'b0;
    accept         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = !out_valid_r || out_ready;
        accept   = in_valid && in_ready;
        if (accept) begin
          out_valid_nxt = 1'b1;
          case (in_item.action)
            ACT_P1_WR: begin
              lock_nxt = !in_item.data[P1_COIN_BIT];
              // falling edge on the irq strobe raises the host interrupt
              if (port1_last_r[P1_IRQ_BIT] && !in_item.data[P1_IRQ_BIT]) begin
                irq_nxt = 1'b1;
              end
              port1_last_nxt = in_item.data;
            end
            ACT_P2_WR: begin
              if (!port2_last_r[P2_STB_BIT] && in_item.data[P2_STB_BIT]) begin
                if (port1_last_r[P1_DIR_BIT]) begin
                  if (!acc_addr[ADDR_SW_BIT]) begin
                    p3_in_nxt = sw_byte;
                  end else if (acc_addr[11:10] == 2'b11) begin
                    // land the RAM byte in the port-3 latch from the READ state
                    ram_re     = 1'b1;
                    rd_vec_nxt = 1'b0;
                    state_nxt  = ST_READ;
                  end
                end else if (acc_addr[11:10] == 2'b11) begin
                  ram_we = 1'b1;
                end
              end
              port2_last_nxt = in_item.data;
            end
            ACT_P3_WR: p3_out_nxt = in_item.data;
            ACT_P4_WR: addr_lo_nxt = in_item.data;
            ACT_P3_RD: rd_byte = p3_in_r;
            ACT_VEC_RD: begin
              irq_nxt       = 1'b0;
              ram_re        = 1'b1;
              ram_vec       = 1'b1;
              rd_vec_nxt    = 1'b1;
              out_valid_nxt = 1'b0;
              state_nxt     = ST_READ;
            end
            default: ;
          endcase
          out_item_nxt.read_data = rd_byte;
          out_item_nxt.host_irq  = irq_nxt;
          out_item_nxt.coin_lock = lock_nxt;
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
        if (rd_vec_r) begin
          out_valid_nxt          = 1'b1;
          out_item_nxt.read_data = ram_rdata;
          out_item_nxt.host_irq  = irq_r;
          out_item_nxt.coin_lock = lock_r;
        end else begin
          p3_in_nxt = ram_rdata;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      port1_last_r <= '0;
      port2_last_r <= '0;
      p3_out_r     <= '0;
      p3_in_r      <= '0;
      addr_lo_r    <= '0;
      irq_r        <= 1'b0;
      lock_r       <= 1'b0;
      rd_vec_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      port1_last_r <= port1_last_nxt;
      port2_last_r <= port2_last_nxt;
      p3_out_r     <= p3_out_nxt;
      p3_in_r      <= p3_in_nxt;
      addr_lo_r    <= addr_lo_nxt;
      irq_r        <= irq_nxt;
      lock_r       <= lock_nxt;
      rd_vec_r     <= rd_vec_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ rtl/core/mpsrb_checker.sv @@
// Port-level checks for the port bridge, bound to the top level.
`include "mcu_port_shared_ram_bridge_macros.svh"

module mpsrb_checker
  import mpsrb_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  logic acc;
  assign acc = in_valid && in_ready;

  // hold a stalled result word
  `MPSRB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_item), "out word changed while stalled")
  `MPSRB_ASSERT_IMP(a_coin, acc && in_item.action == ACT_P1_WR, ##1 (out_valid && out_item.coin_lock == !$past(in_item.data[P1_COIN_BIT])), "coin lock does not follow port1")
  `MPSRB_ASSERT_IMP(a_wr_zero, acc && !in_item.action[2], ##1 (out_valid && out_item.read_data == 8'h00), "port write answered nonzero data")
  `MPSRB_ASSERT_IMP(a_vec_irq, acc && in_item.action == ACT_VEC_RD, ##1 !in_ready ##1 (out_valid && !out_item.host_irq), "vector read left irq set")

endmodule

bind mcu_port_shared_ram_bridge mpsrb_checker u_mpsrb_checker (.*);
